/* rtl/rfb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants of the ring FIFO block: request codes, field
// widths and the command word that travels from the front end to the back end.
// No dependencies.

package rfb_pkg;

    localparam int REQ_W  = 3;
    localparam int WORD_W = 32;
    localparam int CNT_W  = 6;
    localparam int SIZE_W = 7;
    localparam int OCC_W  = 6;
    localparam int FREE_W = 7;

    localparam logic [REQ_W-1:0] REQ_PUSH    = 3'd0;
    localparam logic [REQ_W-1:0] REQ_POP     = 3'd1;
    localparam logic [REQ_W-1:0] REQ_PEEK    = 3'd2;
    localparam logic [REQ_W-1:0] REQ_BPOP    = 3'd3;
    localparam logic [REQ_W-1:0] REQ_BPEEK   = 3'd4;
    localparam logic [REQ_W-1:0] REQ_BREMOVE = 3'd5;
    localparam logic [REQ_W-1:0] REQ_CLEAR   = 3'd6;

    // A decoded request. The flags are worked out by the front end so the back
    // end only has to look at the ring state.
    typedef struct packed {
        logic [REQ_W-1:0]  op;
        logic [WORD_W-1:0] data;
        logic [CNT_W-1:0]  count;
        logic              reads;   // returns stored words
        logic              burst;   // length taken from count
        logic              moves;   // advances the read index
    } t_cmd;

endpackage

`default_nettype wire

/* rtl/rfb_ifs.sv */
`timescale 1ns / 1ps
`default_nettype none
// Valid/ready channel interfaces of the ring FIFO block: request, response
// and configuration. Depends on rfb_pkg for the field widths.

interface rfb_req_if;
    logic                        valid;
    logic                        ready;
    logic [rfb_pkg::REQ_W-1:0]   req_type;
    logic [rfb_pkg::WORD_W-1:0]  data_in;
    logic [rfb_pkg::CNT_W-1:0]   count_req;

    modport source (output valid, req_type, data_in, count_req, input ready);
    modport sink   (input valid, req_type, data_in, count_req, output ready);
endinterface

interface rfb_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [rfb_pkg::WORD_W-1:0]  data_out;
    logic                        data_valid;
    logic [rfb_pkg::CNT_W-1:0]   items_done;
    logic [rfb_pkg::OCC_W-1:0]   occupancy;
    logic [rfb_pkg::FREE_W-1:0]  free_slots;
    logic                        last;

    modport source (output valid, data_out, data_valid, items_done, occupancy,
                    free_slots, last, input ready);
    modport sink   (input valid, data_out, data_valid, items_done, occupancy,
                    free_slots, last, output ready);
endinterface

interface rfb_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [rfb_pkg::SIZE_W-1:0]  ring_size;

    modport source (output valid, ring_size, input ready);
    modport sink   (input valid, ring_size, output ready);
endinterface

`default_nettype wire

/* rtl/rfb_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// Front end of the ring FIFO block: accepts request transactions, decodes
// them into commands and holds them in a two-entry queue for the back end.
// Depends on rfb_pkg and rfb_req_if.

module rfb_front (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    rfb_req_if.sink          i_req,
    output rfb_pkg::t_cmd    o_cmd,
    output logic             o_cmd_valid,
    input  wire logic        i_cmd_take
);

    rfb_pkg::t_cmd r_q [2];
    logic          r_wptr, n_wptr;
    logic          r_rptr, n_rptr;
    logic [1:0]    r_cnt, n_cnt;
    rfb_pkg::t_cmd n_cmd;
    logic          push;
    logic          pop;

    always_comb begin
        n_cmd.op    = i_req.req_type;
        n_cmd.data  = i_req.data_in;
        n_cmd.count = i_req.count_req;
        n_cmd.reads = i_req.req_type inside {rfb_pkg::REQ_POP, rfb_pkg::REQ_PEEK,
                                             rfb_pkg::REQ_BPOP, rfb_pkg::REQ_BPEEK};
        n_cmd.burst = i_req.req_type inside {rfb_pkg::REQ_BPOP, rfb_pkg::REQ_BPEEK};
        n_cmd.moves = i_req.req_type inside {rfb_pkg::REQ_POP, rfb_pkg::REQ_BPOP};
    end

    assign i_req.ready = (r_cnt != 2'd2);
    assign push        = i_req.valid && i_req.ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign pop         = i_cmd_take && o_cmd_valid;
    assign o_cmd       = r_q[r_rptr];

    always_comb begin
        n_wptr = push ? ~r_wptr : r_wptr;
        n_rptr = pop ? ~r_rptr : r_rptr;
        n_cnt  = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= n_cmd;
        end
    end

endmodule

`default_nettype wire

/* rtl/rfb_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// Back end of the ring FIFO block: owns the ring indices, the slot memory and
// the ring size, executes commands and drives the response channel.
// Depends on rfb_pkg and rfb_rsp_if.

module rfb_back #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire rfb_pkg::t_cmd                i_cmd,
    input  wire logic                         i_cmd_valid,
    output logic                              o_cmd_take,
    input  wire logic                         i_cfg_we,
    input  wire logic [rfb_pkg::SIZE_W-1:0]   i_cfg_size,
    rfb_rsp_if.source                         o_rsp
);

    localparam int SW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);
    localparam int CW = (SW + 1 > 7) ? SW + 1 : 7;

    typedef struct packed {
        logic                         dv;
        logic [rfb_pkg::CNT_W-1:0]    done;
        logic [rfb_pkg::OCC_W-1:0]    occ;
        logic [rfb_pkg::FREE_W-1:0]   free;
        logic                         last;
    } t_pend;

    typedef struct packed {
        logic [rfb_pkg::WORD_W-1:0]   data;
        t_pend                        meta;
    } t_out;

    logic [DATA_WIDTH-1:0]  r_mem [DEPTH];
    logic [DATA_WIDTH-1:0]  r_rd_data;

    logic [SW-1:0]              r_eff, n_eff;
    logic [IW-1:0]              r_rd_idx, n_rd_idx;
    logic [IW-1:0]              r_wr_idx, n_wr_idx;
    logic                       r_burst_act, n_burst_act;
    logic [IW-1:0]              r_burst_idx, n_burst_idx;
    logic [rfb_pkg::CNT_W-1:0]  r_burst_left, n_burst_left;
    t_pend                      r_burst_res, n_burst_res;
    logic                       r_pend_valid, n_pend_valid;
    t_pend                      r_pend, n_pend;
    logic                       r_out_valid, n_out_valid;
    t_out                       r_out;

    logic           mem_we;
    logic           mem_re;
    logic [IW-1:0]  raddr;
    logic [CW-1:0]  s_c;
    logic [CW-1:0]  occ_c;
    logic [CW-1:0]  items_c;
    logic           out_load;
    logic           pend_free;

    function automatic logic [IW-1:0] adv(input logic [IW-1:0] idx,
                                          input logic [CW-1:0] by,
                                          input logic [CW-1:0] size);
        logic [CW-1:0] sum;
        sum = CW'(idx) + by;
        if (sum >= size) begin
            sum = sum - size;
        end
        return IW'(sum);
    endfunction

    assign s_c   = CW'(r_eff);
    assign occ_c = (r_wr_idx >= r_rd_idx) ? CW'(r_wr_idx) - CW'(r_rd_idx)
                                          : CW'(r_wr_idx) + s_c - CW'(r_rd_idx);
    assign items_c = (CW'(i_cmd.count) <= occ_c) ? CW'(i_cmd.count) : occ_c;

    assign out_load  = r_pend_valid && (!r_out_valid || o_rsp.ready);
    assign pend_free = !r_pend_valid || out_load;

    always_comb begin
        int            cfg_v;
        logic [CW-1:0] lim;
        logic [CW-1:0] occ_a;
        logic [rfb_pkg::CNT_W-1:0] done;
        logic          dv;
        logic          fin;

        cfg_v        = int'(i_cfg_size);
        lim          = '0;
        occ_a        = occ_c;
        done         = '0;
        dv           = 1'b0;
        fin          = 1'b1;
        n_eff        = r_eff;
        n_rd_idx     = r_rd_idx;
        n_wr_idx     = r_wr_idx;
        n_burst_act  = r_burst_act;
        n_burst_idx  = r_burst_idx;
        n_burst_left = r_burst_left;
        n_burst_res  = r_burst_res;
        n_pend       = r_pend;
        n_pend_valid = r_pend_valid && !out_load;
        o_cmd_take   = 1'b0;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        raddr        = r_rd_idx;

        if (i_cfg_we) begin
            // A new ring size empties the FIFO.
            if (cfg_v < 2) begin
                n_eff = SW'(2);
            end else if (cfg_v > DEPTH) begin
                n_eff = SW'(DEPTH);
            end else begin
                n_eff = SW'(cfg_v);
            end
            n_rd_idx = '0;
            n_wr_idx = '0;
        end else if (r_burst_act) begin
            if (pend_free) begin
                mem_re       = 1'b1;
                raddr        = r_burst_idx;
                n_pend_valid = 1'b1;
                n_pend       = r_burst_res;
                n_pend.last  = (r_burst_left == rfb_pkg::CNT_W'(1));
                n_burst_idx  = adv(r_burst_idx, CW'(1), s_c);
                n_burst_left = r_burst_left - rfb_pkg::CNT_W'(1);
                if (r_burst_left == rfb_pkg::CNT_W'(1)) begin
                    n_burst_act = 1'b0;
                end
            end
        end else if (i_cmd_valid && pend_free) begin
            o_cmd_take = 1'b1;
            if (i_cmd.reads) begin
                if (i_cmd.burst) begin
                    lim = items_c;
                end else begin
                    lim = (occ_c != '0) ? CW'(1) : '0;
                end
                if (lim != '0) begin
                    mem_re = 1'b1;
                    raddr  = r_rd_idx;
                    dv     = 1'b1;
                    done   = rfb_pkg::CNT_W'(lim);
                    if (i_cmd.moves) begin
                        n_rd_idx = adv(r_rd_idx, lim, s_c);
                        occ_a    = occ_c - lim;
                    end
                    // The first word goes out now; the rest follow one a cycle while the result stage is free.
                    if (lim > CW'(1)) begin
                        fin          = 1'b0;
                        n_burst_act  = 1'b1;
                        n_burst_idx  = adv(r_rd_idx, CW'(1), s_c);
                        n_burst_left = rfb_pkg::CNT_W'(lim - CW'(1));
                    end
                end
            end else begin
                case (i_cmd.op)
                    rfb_pkg::REQ_PUSH: begin
                        if (occ_c < s_c - CW'(1)) begin
                            mem_we   = 1'b1;
                            n_wr_idx = adv(r_wr_idx, CW'(1), s_c);
                            occ_a    = occ_c + CW'(1);
                            done     = rfb_pkg::CNT_W'(1);
                        end
                    end
                    rfb_pkg::REQ_BREMOVE: begin
                        n_rd_idx = adv(r_rd_idx, items_c, s_c);
                        occ_a    = occ_c - items_c;
                        done     = rfb_pkg::CNT_W'(items_c);
                    end
                    rfb_pkg::REQ_CLEAR: begin
                        n_rd_idx = '0;
                        n_wr_idx = '0;
                        occ_a    = '0;
                        done     = rfb_pkg::CNT_W'(occ_c);
                    end
                    default: begin
                    end
                endcase
            end
            n_pend_valid     = 1'b1;
            n_pend.dv        = dv;
            n_pend.done      = done;
            n_pend.occ       = rfb_pkg::OCC_W'(occ_a);
            n_pend.free      = rfb_pkg::FREE_W'(s_c - occ_a);
            n_pend.last      = fin;
            n_burst_res      = n_pend;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eff        <= SW'(DEPTH);
            r_rd_idx     <= '0;
            r_wr_idx     <= '0;
            r_burst_act  <= 1'b0;
            r_burst_left <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_eff        <= n_eff;
            r_rd_idx     <= n_rd_idx;
            r_wr_idx     <= n_wr_idx;
            r_burst_act  <= n_burst_act;
            r_burst_left <= n_burst_left;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_burst_idx <= n_burst_idx;
        r_burst_res <= n_burst_res;
        r_pend      <= n_pend;
        if (out_load) begin
            r_out.data <= r_pend.dv ? rfb_pkg::WORD_W'(r_rd_data) : '0;
            r_out.meta <= r_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_wr_idx] <= DATA_WIDTH'(i_cmd.data);
        end
        if (mem_re) begin
            r_rd_data <= r_mem[raddr];
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.data_out   = r_out.data;
    assign o_rsp.data_valid = r_out.meta.dv;
    assign o_rsp.items_done = r_out.meta.done;
    assign o_rsp.occupancy  = r_out.meta.occ;
    assign o_rsp.free_slots = r_out.meta.free;
    assign o_rsp.last       = r_out.meta.last;

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (SW'(r_rd_idx) < r_eff) && (SW'(r_wr_idx) < r_eff))
        else $error("ring index outside the ring");

    a_burst_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_burst_act |-> (r_burst_left != '0))
        else $error("burst active with no words left");

    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_take |-> (!r_burst_act && pend_free))
        else $error("command taken while a burst or the result stage is busy");

    a_pend_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend_valid && r_out_valid && !o_rsp.ready) |=>
        (r_pend_valid && $stable(r_pend)))
        else $error("pending result lost under stall");

    a_burst_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_burst_act && !pend_free) |=> (r_burst_act && $stable(r_burst_left)))
        else $error("burst advanced while stalled");

endmodule

`default_nettype wire

/* rtl/ring_fifo_burst.sv */
`timescale 1ns / 1ps
`default_nettype none
// Top level of the ring FIFO block: front end, command queue and back end.
// Depends on rfb_pkg, rfb_ifs, rfb_front and rfb_back.
//
//   channel   direction  type        moves
//   i_req     in         rfb_req_if  one request per transaction
//   o_rsp     out        rfb_rsp_if  one result per transaction
//   i_cfg     in         rfb_cfg_if  ring size write, always ready
//
// Push, pop, peek, remove and clear sustain one transaction per cycle while
// the response side does not stall; a burst read returns its words one after
// another, limited by the single read port of the slot memory.
// An accepted request is written into the command queue; the back end then
// reads the slot memory and registers the pending result, and the output
// register holds it for the response channel. Reset sets the ring size to
// DEPTH and empties the FIFO. The two-entry command queue buffers requests
// while the response side stalls; the output register holds a result until taken.

module ring_fifo_burst #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    rfb_req_if.sink     i_req,
    rfb_rsp_if.source   o_rsp,
    rfb_cfg_if.sink     i_cfg
);

    rfb_pkg::t_cmd cmd;
    logic          cmd_valid;
    logic          cmd_take;

    assign i_cfg.ready = 1'b1;

    rfb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_cmd       (cmd),
        .o_cmd_valid (cmd_valid),
        .i_cmd_take  (cmd_take)
    );

    rfb_back #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .o_cmd_take  (cmd_take),
        .i_cfg_we    (i_cfg.valid && i_cfg.ready),
        .i_cfg_size  (i_cfg.ring_size),
        .o_rsp       (o_rsp)
    );

endmodule

`default_nettype wire

/* dv/ring_fifo_burst_checker.sv */
`timescale 1ns / 1ps
// Checker for the ring FIFO block: mirrors the ring state, predicts each result
// of every accepted request and compares the observed results in order.
// Depends on rfb_pkg and the channel interfaces in rfb_ifs.

module ring_fifo_burst_checker #(
    parameter int DEPTH = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    rfb_req_if   i_req,
    rfb_rsp_if   i_rsp,
    rfb_cfg_if   i_cfg,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_results_checked
);

    typedef struct packed {
        logic [rfb_pkg::WORD_W-1:0] data;
        logic                       data_valid;
        logic [rfb_pkg::CNT_W-1:0]  items_done;
        logic [rfb_pkg::OCC_W-1:0]  occupancy;
        logic [rfb_pkg::FREE_W-1:0] free_slots;
        logic                       last;
    } t_fifo_result;

    t_fifo_result               pending_results[$];
    logic [rfb_pkg::WORD_W-1:0] slot_mem [DEPTH];
    int unsigned                rd_ptr;
    int unsigned                wr_ptr;
    logic [rfb_pkg::SIZE_W-1:0] ring_size_q;
    int                         fail_count = 0;
    int                         checked_count = 0;

    assign o_fail_count      = fail_count;
    assign o_results_checked = checked_count;

    // Ring sizes outside 2..DEPTH are clamped.
    function automatic int unsigned ring_span();
        int unsigned s;
        s = ring_size_q;
        if (s < 2) s = 2;
        if (s > DEPTH) s = DEPTH;
        return s;
    endfunction

    function automatic int unsigned fill_level();
        int unsigned s;
        int unsigned r;
        int unsigned w;
        s = ring_span();
        r = rd_ptr % s;
        w = wr_ptr % s;
        return (w >= r) ? (w - r) : (w + s - r);
    endfunction

    function automatic int unsigned step_ptr(input int unsigned p, input int unsigned by);
        int unsigned s;
        s = ring_span();
        return (p % s + by % s) % s;
    endfunction

    task automatic report_mismatch(input string msg);
        fail_count++;
        $display("[%0t] %s", $time, msg);
    endtask

    // Occupancy and free slots are taken from the state after the request.
    task automatic expect_result(input logic [rfb_pkg::WORD_W-1:0] word, input logic valid,
                                 input int unsigned done, input logic fin);
        t_fifo_result r;
        int unsigned  occ;
        int unsigned  free_cnt;
        occ          = fill_level();
        free_cnt     = ring_span() - occ;
        r.data       = word;
        r.data_valid = valid;
        r.items_done = done[rfb_pkg::CNT_W-1:0];
        r.occupancy  = occ[rfb_pkg::OCC_W-1:0];
        r.free_slots = free_cnt[rfb_pkg::FREE_W-1:0];
        r.last       = fin;
        pending_results.push_back(r);
    endtask

    task automatic predict_request(input logic [rfb_pkg::REQ_W-1:0] op,
                                   input logic [rfb_pkg::WORD_W-1:0] word,
                                   input logic [rfb_pkg::CNT_W-1:0] cnt);
        int unsigned                occ;
        int unsigned                items;
        int unsigned                idx;
        logic [rfb_pkg::WORD_W-1:0] rd_word;
        occ = fill_level();
        case (op)
            rfb_pkg::REQ_PUSH: begin
                if (occ < ring_span() - 1) begin
                    slot_mem[wr_ptr % DEPTH] = word;
                    wr_ptr = step_ptr(wr_ptr, 1);
                    expect_result('0, 1'b0, 1, 1'b1);
                end else begin
                    expect_result('0, 1'b0, 0, 1'b1);
                end
            end
            rfb_pkg::REQ_POP, rfb_pkg::REQ_PEEK: begin
                if (occ == 0) begin
                    expect_result('0, 1'b0, 0, 1'b1);
                end else begin
                    rd_word = slot_mem[rd_ptr % DEPTH];
                    if (op == rfb_pkg::REQ_POP) rd_ptr = step_ptr(rd_ptr, 1);
                    expect_result(rd_word, 1'b1, 1, 1'b1);
                end
            end
            rfb_pkg::REQ_BPOP, rfb_pkg::REQ_BPEEK: begin
                items = (cnt <= occ) ? cnt : occ;
                if (items == 0) begin
                    expect_result('0, 1'b0, 0, 1'b1);
                end else begin
                    idx = rd_ptr;
                    if (op == rfb_pkg::REQ_BPOP) rd_ptr = step_ptr(rd_ptr, items);
                    for (int unsigned i = 0; i < items; i++) begin
                        expect_result(slot_mem[idx % DEPTH], 1'b1, items, i + 1 == items);
                        idx = step_ptr(idx, 1);
                    end
                end
            end
            rfb_pkg::REQ_BREMOVE: begin
                items = (cnt <= occ) ? cnt : occ;
                rd_ptr = step_ptr(rd_ptr, items);
                expect_result('0, 1'b0, items, 1'b1);
            end
            rfb_pkg::REQ_CLEAR: begin
                rd_ptr = 0;
                wr_ptr = 0;
                expect_result('0, 1'b0, occ, 1'b1);
            end
            default: begin
                expect_result('0, 1'b0, 0, 1'b1);
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_fifo_result want;
        if (!i_rst_n) begin
            pending_results.delete();
            rd_ptr      = 0;
            wr_ptr      = 0;
            ring_size_q = rfb_pkg::SIZE_W'(DEPTH);
        end else begin
            // Compare first so a result is never matched against a request
            // accepted on the same edge.
            if (i_rsp.valid && i_rsp.ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch($sformatf("result with no request waiting, data_out %h",
                                              i_rsp.data_out));
                end else begin
                    want = pending_results.pop_front();
                    checked_count++;
                    if (i_rsp.data_out !== want.data)
                        report_mismatch($sformatf("data_out got %h, want %h",
                                                  i_rsp.data_out, want.data));
                    if (i_rsp.data_valid !== want.data_valid)
                        report_mismatch($sformatf("data_valid got %b, want %b",
                                                  i_rsp.data_valid, want.data_valid));
                    if (i_rsp.items_done !== want.items_done)
                        report_mismatch($sformatf("items_done got %0d, want %0d",
                                                  i_rsp.items_done, want.items_done));
                    if (i_rsp.occupancy !== want.occupancy)
                        report_mismatch($sformatf("occupancy got %0d, want %0d",
                                                  i_rsp.occupancy, want.occupancy));
                    if (i_rsp.free_slots !== want.free_slots)
                        report_mismatch($sformatf("free_slots got %0d, want %0d",
                                                  i_rsp.free_slots, want.free_slots));
                    if (i_rsp.last !== want.last)
                        report_mismatch($sformatf("last got %b, want %b",
                                                  i_rsp.last, want.last));
                end
            end
            if (i_cfg.valid && i_cfg.ready) begin
                ring_size_q = i_cfg.ring_size;
                rd_ptr      = 0;
                wr_ptr      = 0;
            end
            if (i_req.valid && i_req.ready)
                predict_request(i_req.req_type, i_req.data_in, i_req.count_req);
        end
        o_pending = pending_results.size();
    end

endmodule

/* dv/ring_fifo_burst_tb.sv */
`timescale 1ns / 1ps
// Top of the ring FIFO testbench: clock, reset, request and ring size stimulus,
// response back-pressure, watchdog and verdict.
// Depends on rfb_pkg, rfb_ifs, ring_fifo_burst and ring_fifo_burst_checker.

module ring_fifo_burst_tb;

    localparam int                        DEPTH          = 64;
    localparam int                        WATCHDOG_LIMIT = 2000;
    localparam int                        PHASE_ITEMS    = 28;
    localparam logic [rfb_pkg::REQ_W-1:0] REQ_UNUSED     = 3'd7;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic idle_en = 1'b1;
    int   fail_count;
    int   pending_cnt;
    int   results_checked;
    int   req_count = 0;
    int   size_writes = 0;
    int   quiet_cycles = 0;

    always #5 clk = ~clk;

    rfb_req_if req_ch ();
    rfb_rsp_if rsp_ch ();
    rfb_cfg_if cfg_ch ();

    ring_fifo_burst #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (rfb_pkg::WORD_W)
    ) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    ring_fifo_burst_checker #(
        .DEPTH (DEPTH)
    ) result_check (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_req             (req_ch),
        .i_rsp             (rsp_ch),
        .i_cfg             (cfg_ch),
        .o_fail_count      (fail_count),
        .o_pending         (pending_cnt),
        .o_results_checked (results_checked)
    );

    // The receiver stalls at random, about a fifth of the time, while idling is enabled.
    always @(negedge clk) begin
        rsp_ch.ready <= idle_en ? ($urandom_range(99) >= 21) : 1'b1;
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Called and returns at a falling edge; valid stays high for back-to-back requests.
    task automatic send_req(input logic [rfb_pkg::REQ_W-1:0] op,
                            input logic [rfb_pkg::WORD_W-1:0] word,
                            input logic [rfb_pkg::CNT_W-1:0] cnt);
        if (idle_en && $urandom_range(99) < 21) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.req_type  <= op;
        req_ch.data_in   <= word;
        req_ch.count_req <= cnt;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        req_count++;
        @(negedge clk);
    endtask

    task automatic hold_until_drained();
        req_ch.valid <= 1'b0;
        while (pending_cnt != 0) @(negedge clk);
        // Leave room for any stray result to show up.
        repeat (8) @(negedge clk);
    endtask

    task automatic write_ring_size(input logic [rfb_pkg::SIZE_W-1:0] size_val);
        hold_until_drained();
        cfg_ch.valid     <= 1'b1;
        cfg_ch.ring_size <= size_val;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        size_writes++;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Mostly short bursts, now and then anything up to the field maximum.
    function automatic logic [rfb_pkg::CNT_W-1:0] burst_len();
        return ($urandom_range(3) == 0) ? rfb_pkg::CNT_W'($urandom_range(0, 63))
                                        : rfb_pkg::CNT_W'($urandom_range(0, 6));
    endfunction

    task automatic random_phase(input int n_items);
        int k;
        int r;
        int run;
        int push_pct;
        k = 0;
        while (k < n_items) begin
            r = $urandom_range(99);
            push_pct = (k < n_items / 2) ? 55 : 25;
            if (r < 20) begin
                // A bulk push followed by a burst read of about that length.
                run = $urandom_range(1, 8);
                repeat (run) send_req(rfb_pkg::REQ_PUSH, $urandom,
                                      rfb_pkg::CNT_W'($urandom));
                send_req($urandom_range(1) ? rfb_pkg::REQ_BPOP : rfb_pkg::REQ_BPEEK,
                         $urandom, rfb_pkg::CNT_W'($urandom_range(1, run + 2)));
                k += run + 1;
            end else begin
                r = $urandom_range(99);
                if ($urandom_range(99) < push_pct)
                    send_req(rfb_pkg::REQ_PUSH, $urandom, rfb_pkg::CNT_W'($urandom));
                else if (r < 14)
                    send_req(rfb_pkg::REQ_POP, $urandom, rfb_pkg::CNT_W'($urandom));
                else if (r < 26)
                    send_req(rfb_pkg::REQ_PEEK, $urandom, rfb_pkg::CNT_W'($urandom));
                else if (r < 50) send_req(rfb_pkg::REQ_BPOP, $urandom, burst_len());
                else if (r < 72) send_req(rfb_pkg::REQ_BPEEK, $urandom, burst_len());
                else if (r < 93) send_req(rfb_pkg::REQ_BREMOVE, $urandom, burst_len());
                else if (r < 97)
                    send_req(rfb_pkg::REQ_CLEAR, $urandom, rfb_pkg::CNT_W'($urandom));
                else send_req(REQ_UNUSED, $urandom, rfb_pkg::CNT_W'($urandom));
                k++;
            end
        end
    endtask

    initial begin
        logic [rfb_pkg::SIZE_W-1:0] phase_sizes [10];
        phase_sizes = '{7'd64, 7'd2, 7'd3, 7'd127, 7'd7, 7'd1, 7'd33, 7'd0, 7'd64, 7'd0};
        phase_sizes[9] = rfb_pkg::SIZE_W'($urandom_range(0, 127));

        req_ch.valid     = 1'b0;
        req_ch.req_type  = rfb_pkg::REQ_PUSH;
        req_ch.data_in   = '0;
        req_ch.count_req = '0;
        rsp_ch.ready     = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.ring_size = '0;

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        write_ring_size(rfb_pkg::SIZE_W'(DEPTH));

        // Empty FIFO: every read kind and a remove, then the unused request code, then four pushes.
        send_req(rfb_pkg::REQ_POP, 32'h0, 6'd0);
        send_req(rfb_pkg::REQ_PEEK, 32'h0, 6'd0);
        send_req(rfb_pkg::REQ_BPOP, 32'h0, 6'd5);
        send_req(rfb_pkg::REQ_BPEEK, 32'h0, 6'd63);
        send_req(rfb_pkg::REQ_BREMOVE, 32'h0, 6'd3);
        send_req(REQ_UNUSED, 32'h0, 6'd0);
        send_req(rfb_pkg::REQ_PUSH, 32'h0000_0000, 6'd0);
        send_req(rfb_pkg::REQ_PUSH, 32'hFFFF_FFFF, 6'd63);
        send_req(rfb_pkg::REQ_PUSH, 32'hAAAA_AAAA, 6'd42);
        send_req(rfb_pkg::REQ_PUSH, 32'h5555_5555, 6'd21);
        // The sender holds off here until every result is back.
        hold_until_drained();
        send_req(rfb_pkg::REQ_PEEK, 32'h0, 6'd0);
        send_req(rfb_pkg::REQ_BPEEK, 32'h0, 6'd0);
        send_req(rfb_pkg::REQ_BPEEK, 32'h0, 6'd63);
        send_req(rfb_pkg::REQ_POP, 32'h0, 6'd0);
        send_req(rfb_pkg::REQ_BPOP, 32'h0, 6'd2);
        send_req(rfb_pkg::REQ_BREMOVE, 32'h0, 6'd63);
        send_req(rfb_pkg::REQ_PUSH, 32'h1234_5678, 6'd0);
        send_req(rfb_pkg::REQ_PUSH, 32'h8000_0001, 6'd0);
        send_req(rfb_pkg::REQ_CLEAR, 32'h0, 6'd0);
        send_req(REQ_UNUSED, 32'hFFFF_FFFF, 6'd63);

        // A ring size below the minimum holds a single word.
        write_ring_size(7'd0);
        send_req(rfb_pkg::REQ_PUSH, 32'hCAFE_F00D, 6'd0);
        send_req(rfb_pkg::REQ_PUSH, 32'h0BAD_0BAD, 6'd0);
        send_req(rfb_pkg::REQ_BPOP, 32'h0, 6'd63);

        for (int p = 0; p < 10; p++) begin
            write_ring_size(phase_sizes[p]);
            if (p == 3) begin
                // No idling here, and the clamped full-size ring is filled past full.
                idle_en = 1'b0;
                repeat (DEPTH) send_req(rfb_pkg::REQ_PUSH, $urandom,
                                        rfb_pkg::CNT_W'($urandom));
                random_phase(PHASE_ITEMS - 6);
                idle_en = 1'b1;
            end else begin
                random_phase(PHASE_ITEMS);
            end
        end

        hold_until_drained();
        $display("Covered %0d requests and %0d checked results over %0d ring size writes,",
                 req_count, results_checked, size_writes);
        $display("with empty, full and clamped rings and stalls on both channels.");
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
